FILE: rtl/ccs_pkg.sv
// Package for the containing cube search block.
// Holds the beat payload types, command and status codes, and the
// controller/datapath command and status structs. No dependencies.
package ccs_pkg;

  localparam int unsigned CUBE_W   = 63;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned DIGIT_W  = 5;

  localparam logic [DIGIT_W-1:0] DIGIT_RST = 5'd30;

  // Command codes carried in the input beat.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Status codes carried in the output beat.
  localparam logic [STATUS_W-1:0] STS_FOUND    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_MISS     = 2'd1;
  localparam logic [STATUS_W-1:0] STS_DROPPED  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CUBE_W-1:0] cube_bits;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  cube_index;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } ccs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;
    logic clear;
    logic query_start;
    logic scan;
    logic set_found;
    logic set_miss;
    logic set_full;
    logic out_load;
  } ccs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic last;
  } ccs_sts_t;

endpackage

FILE: rtl/containing_cube_search.sv
// Top level of the containing cube search block.
// Depends on ccs_pkg, ccs_ctrl, ccs_dp and ccs_ram.
//
// This block holds a table of up to MAX_CUBES logic cubes in positional
// notation, filled in load order, and answers which stored cube is the first
// to contain a query cube over the low 2*digit_count bits. A load or clear
// beat gives no result; a load into a full table gives a "dropped" result.
// A query walks the table one entry per cycle through the single read port
// of the table memory, whose read data is registered. Input beats are taken
// only while no query or result is in progress. A finished result sits in
// an output register until it is taken, and the block accepts the next beat
// as soon as that result has moved into the output register, even while it
// is stalled there. The table memory needs no clearing pass: the fill count
// alone marks which entries are valid. The digit count register should be
// written only while the block is idle; values above MAX_DIGITS act as
// MAX_DIGITS.
module containing_cube_search
  import ccs_pkg::*;
#(
  parameter int unsigned MAX_CUBES  = 1024,
  parameter int unsigned MAX_DIGITS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DIGIT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_beat_t           in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_beat_t          out_beat_o
);

  localparam int unsigned CW = $clog2(MAX_CUBES + 1);

  ccs_cmd_t      cmd;
  ccs_sts_t      sts;
  logic [CW-1:0] count;

  // The controller sequences loads, clears and the table scan.
  ccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (in_beat_i.command),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath owns the table, the fill count and the compare.
  ccs_dp #(
    .MAX_CUBES (MAX_CUBES),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cube_bits_i(in_beat_i.cube_bits),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .count_o    (count),
    .out_beat_o (out_beat_o)
  );

  // The fill count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(MAX_CUBES))
    else $error("fill count above table depth");

  // A new result never overwrites one that is still stalled at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("output beat overwritten while stalled");

  // A load beat into a table with room grows the fill count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_beat_i.command == CMD_LOAD) && !sts.full)
      |=> (count == $past(count) + CW'(1)))
    else $error("load did not advance the fill count");

endmodule

FILE: rtl/ccs_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ccs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ccs_ctrl.sv
// Controller state machine of the containing cube search block.
// Depends on ccs_pkg for the state enum and the command/status structs.
module ccs_ctrl
  import ccs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] command_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  ccs_sts_t         sts_i,
  output ccs_cmd_t         cmd_o
);

  ccs_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_LOAD:  state_d = sts_i.full ? ST_RESULT : ST_IDLE;
            CMD_QUERY: state_d = sts_i.empty ? ST_RESULT : ST_SCAN;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts_i.hit || sts_i.last) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_LOAD: begin
              cmd_o.store    = !sts_i.full;
              cmd_o.set_full = sts_i.full;
            end
            CMD_QUERY: begin
              cmd_o.query_start = 1'b1;
              cmd_o.set_miss    = sts_i.empty;
            end
            CMD_CLEAR: cmd_o.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan      = 1'b1;
        cmd_o.set_found = sts_i.hit;
        cmd_o.set_miss  = !sts_i.hit && sts_i.last;
      end
      ST_RESULT: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/ccs_dp.sv
// Datapath of the containing cube search block: cube table, fill count,
// query register, containment compare and result registers.
// Depends on ccs_pkg and ccs_ram.
module ccs_dp
  import ccs_pkg::*;
#(
  parameter int unsigned MAX_CUBES  = 1024,
  parameter int unsigned MAX_DIGITS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DIGIT_W-1:0] cfg_wdata_i,
  input  logic [CUBE_W-1:0]  cube_bits_i,
  input  ccs_cmd_t           cmd_i,
  output ccs_sts_t           sts_o,
  output logic [$clog2(MAX_CUBES+1)-1:0] count_o,
  output out_beat_t          out_beat_o
);

  localparam int unsigned CW = $clog2(MAX_CUBES + 1);
  localparam int unsigned AW = (MAX_CUBES > 1) ? $clog2(MAX_CUBES) : 1;
  localparam logic [CW-1:0]      MaxCount = CW'(MAX_CUBES);
  localparam logic [DIGIT_W-1:0] MaxDig   = DIGIT_W'(MAX_DIGITS);

  logic [DIGIT_W-1:0] digit_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]      cmp_idx_q, cmp_idx_d;
  logic               data_vld_q, data_vld_d;
  logic [CUBE_W-1:0]  query_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [INDEX_W-1:0]  res_index_q;
  out_beat_t          out_beat_q;

  logic [DIGIT_W-1:0] digit_eff;
  logic [CUBE_W-1:0]  digit_mask;
  logic               rd_en;
  logic [CUBE_W-1:0]  rd_data;
  logic               match;
  logic [CW+INDEX_W-1:0] idx_wide;

  // Saturate the digit count, then enable the low 2*digits bits.
  assign digit_eff = (digit_q > MaxDig) ? MaxDig : digit_q;

  always_comb begin
    for (int b = 0; b < CUBE_W; b++) begin
      digit_mask[b] = (6'(b) < {digit_eff, 1'b0});
    end
  end

  assign rd_en = cmd_i.scan && (rd_ptr_q < count_q);

  ccs_ram #(
    .WIDTH(CUBE_W),
    .DEPTH(MAX_CUBES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(cube_bits_i),
    .re_i   (rd_en),
    .raddr_i(rd_ptr_q[AW-1:0]),
    .rdata_o(rd_data)
  );

  assign match    = ((query_q & ~rd_data) == '0);
  assign idx_wide = {{INDEX_W{1'b0}}, cmp_idx_q};

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.store) begin
      count_d = count_q + CW'(1);
    end
  end

  always_comb begin
    rd_ptr_d   = rd_ptr_q;
    cmp_idx_d  = cmp_idx_q;
    data_vld_d = 1'b0;
    if (cmd_i.query_start) begin
      rd_ptr_d = '0;
    end else if (cmd_i.scan) begin
      data_vld_d = rd_en;
      cmp_idx_d  = rd_ptr_q;
      if (rd_en) begin
        rd_ptr_d = rd_ptr_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q    <= DIGIT_RST;
      count_q    <= '0;
      rd_ptr_q   <= '0;
      cmp_idx_q  <= '0;
      data_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        digit_q <= cfg_wdata_i;
      end
      count_q    <= count_d;
      rd_ptr_q   <= rd_ptr_d;
      cmp_idx_q  <= cmp_idx_d;
      data_vld_q <= data_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      query_q <= cube_bits_i & digit_mask;
    end
    if (cmd_i.set_found) begin
      res_status_q <= STS_FOUND;
      res_index_q  <= idx_wide[INDEX_W-1:0];
    end else if (cmd_i.set_miss) begin
      res_status_q <= STS_MISS;
      res_index_q  <= '0;
    end else if (cmd_i.set_full) begin
      res_status_q <= STS_DROPPED;
      res_index_q  <= '0;
    end
    if (cmd_i.out_load) begin
      out_beat_q.status     <= res_status_q;
      out_beat_q.cube_index <= res_index_q;
    end
  end

  assign sts_o.full  = (count_q == MaxCount);
  assign sts_o.empty = (count_q == '0);
  assign sts_o.hit   = data_vld_q && match;
  assign sts_o.last  = data_vld_q && (cmp_idx_q == (count_q - CW'(1)));
  assign count_o     = count_q;
  assign out_beat_o  = out_beat_q;

endmodule
